// ===== hdl/srt_pkg.sv =====
// Package for the scale/rotate/translate matrix builder.
// Holds payload structs, fixed-point constants and the CORDIC arctangent table.
// No dependencies.
package srt_pkg;

  localparam int CordicStagesDef = 16;
  localparam int AtanLen         = 24;

  localparam logic signed [33:0] Q28Pi     = 34'sd843314857;
  localparam logic signed [33:0] Q28TwoPi  = 34'sd1686629713;
  localparam logic signed [33:0] Q28HalfPi = 34'sd421657428;
  localparam logic signed [33:0] Q30Gain   = 34'sd652032874;
  localparam logic [31:0]        Q16One    = 32'h0001_0000;

  typedef struct packed {
    logic signed [31:0] scale_x;
    logic signed [31:0] scale_y;
    logic signed [31:0] scale_z;
    logic signed [15:0] angle_x;
    logic signed [15:0] angle_y;
    logic signed [15:0] angle_z;
    logic signed [31:0] trans_x;
    logic signed [31:0] trans_y;
    logic signed [31:0] trans_z;
  } srt_in_t;

  typedef struct packed {
    logic [1:0]         row_index;
    logic signed [31:0] col0;
    logic signed [31:0] col1;
    logic signed [31:0] col2;
    logic signed [31:0] col3;
    logic               last_row;
  } srt_out_t;

  // Sine/cosine pair, Q2.30 (34 bits holds CORDIC growth).
  typedef struct packed {
    logic signed [33:0] s;
    logic signed [33:0] c;
  } srt_sc_t;

  function automatic logic signed [33:0] atan_q28(input logic [4:0] i);
    logic signed [33:0] v;
    unique case (i)
      5'd0:  v = 34'sd210828714;
      5'd1:  v = 34'sd124459457;
      5'd2:  v = 34'sd65760959;
      5'd3:  v = 34'sd33381290;
      5'd4:  v = 34'sd16755422;
      5'd5:  v = 34'sd8385879;
      5'd6:  v = 34'sd4193963;
      5'd7:  v = 34'sd2097109;
      5'd8:  v = 34'sd1048571;
      5'd9:  v = 34'sd524287;
      5'd10: v = 34'sd262144;
      5'd11: v = 34'sd131072;
      5'd12: v = 34'sd65536;
      5'd13: v = 34'sd32768;
      5'd14: v = 34'sd16384;
      5'd15: v = 34'sd8192;
      5'd16: v = 34'sd4096;
      5'd17: v = 34'sd2048;
      5'd18: v = 34'sd1024;
      5'd19: v = 34'sd512;
      5'd20: v = 34'sd256;
      5'd21: v = 34'sd128;
      5'd22: v = 34'sd64;
      5'd23: v = 34'sd32;
      default: v = 34'sd0;
    endcase
    return v;
  endfunction

  // Floored Q2.30 product.
  function automatic logic signed [33:0] mul30(input logic signed [33:0] a,
                                               input logic signed [33:0] b);
    logic signed [67:0] p;
    p = a * b;
    return p[63:30];
  endfunction

  // Q16.16 scale times Q2.30 rotation, round half up, saturate.
  function automatic logic signed [31:0] scaled(input logic signed [31:0] sc,
                                                input logic signed [33:0] r);
    logic signed [65:0] p;
    logic signed [35:0] v;
    p = 66'(sc) * 66'(r) + 66'sd536870912;
    v = p[65:30];
    if (v > 36'sd2147483647)       return 32'h7FFF_FFFF;
    else if (v < -36'sd2147483648) return 32'h8000_0000;
    else                           return v[31:0];
  endfunction

endpackage

// ===== hdl/srt_affine_matrix_builder.sv =====
// Scale/rotate/translate world matrix builder, four row beats per item.
// Row 0 is valid once an accepted input beat has passed the CORDIC and matrix stages
// and the row buffer. The pipe takes new items while the rows of an earlier item go out.
// Pipeline stalls as a whole only while a finished item waits at its tail for the
// row serializer. Reset (rst_n, synchronous) clears all valid bits and the row counter.
module srt_affine_matrix_builder import srt_pkg::*; #(
  parameter int CORDIC_STAGES = CordicStagesDef
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  srt_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output srt_out_t out_data
);
  logic           cv, mv, en;
  srt_in_t        cd;
  srt_sc_t [2:0]  csc;
  srt_out_t [3:0] mrows;

  // Serializer: hold four rows, emit one beat each.
  logic           busy_r;
  srt_out_t [3:0] buf_r;
  logic [1:0]     row_r;

  logic take;
  // Advance pipe unless a finished item is stuck at its tail.
  assign take = mv && (!busy_r || (out_ready && row_r == 2'd3));
  assign en   = !mv || take;
  assign in_ready = en;

  srt_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_cordic (
    .clk, .rst_n, .en, .in_vld(in_valid), .in_data,
    .out_vld(cv), .out_data(cd), .out_sc(csc)
  );

  srt_matrix u_matrix (
    .clk, .rst_n, .en, .in_vld(cv), .in_data(cd), .in_sc(csc),
    .out_vld(mv), .out_rows(mrows)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      row_r  <= 2'd0;
    end else begin
      if (take) begin
        busy_r <= 1'b1;
        row_r  <= 2'd0;
        buf_r  <= mrows;
      end else if (busy_r && out_ready) begin
        row_r  <= row_r + 2'd1;
        if (row_r == 2'd3) busy_r <= 1'b0;
      end
    end
  end

  assign out_valid = busy_r;
  assign out_data  = buf_r[row_r];

  // Row index on the bus matches the serializer count.
  a_row_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.row_index == row_r) else $error("row index mismatch");
  // Last flag only on row 3.
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.last_row == (row_r == 2'd3))) else $error("last_row wrong");
  // A delivered non-last row is followed by the next row.
  a_adv: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && row_r != 2'd3) |=> (out_valid && row_r == $past(row_r) + 2'd1))
    else $error("row sequence broken");
endmodule

// ===== hdl/srt_cordic.sv =====
// Pipelined rotation-mode CORDIC: three angles in lock step, one stage per register.
// Depends on srt_pkg.
module srt_cordic import srt_pkg::*; #(
  parameter int CORDIC_STAGES = CordicStagesDef
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_vld,
  input  srt_in_t            in_data,
  output logic               out_vld,
  output srt_in_t            out_data,
  output srt_sc_t [2:0]      out_sc
);
  localparam int N = (CORDIC_STAGES < AtanLen) ? CORDIC_STAGES : AtanLen;

  logic    [N:0]              vld_r;
  srt_in_t                    dat_r [N+1];
  logic signed [33:0]         x_r [N+1][3];
  logic signed [33:0]         y_r [N+1][3];
  logic signed [33:0]         z_r [N+1][3];
  logic        [2:0]          neg_r [N+1];

  logic signed [33:0] z0 [3];
  logic        [2:0]  neg0;

  // Reduce Q4.12 angles (at most about 1.3 turns) to [-pi/2, pi/2].
  always_comb begin
    logic signed [33:0] z;
    logic signed [15:0] a [3];
    a[0] = in_data.angle_x;
    a[1] = in_data.angle_y;
    a[2] = in_data.angle_z;
    for (int k = 0; k < 3; k++) begin
      z = {{2{a[k][15]}}, a[k], 16'd0};
      if (z > Q28Pi) z = z - Q28TwoPi;
      if (z > Q28Pi) z = z - Q28TwoPi;
      if (z < -Q28Pi) z = z + Q28TwoPi;
      if (z < -Q28Pi) z = z + Q28TwoPi;
      neg0[k] = 1'b0;
      if (z > Q28HalfPi) begin
        z = z - Q28Pi;
        neg0[k] = 1'b1;
      end else if (z < -Q28HalfPi) begin
        z = z + Q28Pi;
        neg0[k] = 1'b1;
      end
      z0[k] = z;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[N-1:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dat_r[0] <= in_data;
      neg_r[0] <= neg0;
      for (int k = 0; k < 3; k++) begin
        x_r[0][k] <= Q30Gain;
        y_r[0][k] <= '0;
        z_r[0][k] <= z0[k];
      end
      for (int i = 0; i < N; i++) begin
        dat_r[i+1] <= dat_r[i];
        neg_r[i+1] <= neg_r[i];
        for (int k = 0; k < 3; k++) begin
          if (!z_r[i][k][33]) begin
            x_r[i+1][k] <= x_r[i][k] - (y_r[i][k] >>> i);
            y_r[i+1][k] <= y_r[i][k] + (x_r[i][k] >>> i);
            z_r[i+1][k] <= z_r[i][k] - atan_q28(5'(i));
          end else begin
            x_r[i+1][k] <= x_r[i][k] + (y_r[i][k] >>> i);
            y_r[i+1][k] <= y_r[i][k] - (x_r[i][k] >>> i);
            z_r[i+1][k] <= z_r[i][k] + atan_q28(5'(i));
          end
        end
      end
    end
  end

  assign out_vld  = vld_r[N];
  assign out_data = dat_r[N];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      out_sc[k].c = neg_r[N][k] ? -x_r[N][k] : x_r[N][k];
      out_sc[k].s = neg_r[N][k] ? -y_r[N][k] : y_r[N][k];
    end
  end
endmodule

// ===== hdl/srt_matrix.sv =====
// Rotation matrix products and scaling, three register stages.
// Depends on srt_pkg.
module srt_matrix import srt_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_vld,
  input  srt_in_t       in_data,
  input  srt_sc_t [2:0] in_sc,
  output logic          out_vld,
  output srt_out_t [3:0] out_rows
);
  logic [2:0] vld_r;
  srt_in_t d1_r, d2_r;
  logic signed [33:0] r00_r, r01_r, r02_r, r12_r, r22_r;
  logic signed [33:0] cxsz_r, cxcz_r, sxsz_r, sxcz_r, sxsy_r, cxsy_r, cz_r2, sz_r2;
  logic signed [33:0] r10_r, r11_r, r20_r, r21_r, r00b_r, r01b_r, r02b_r, r12b_r, r22b_r;
  srt_out_t [3:0] rows_r;

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (en) vld_r <= {vld_r[1:0], in_vld};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // Stage A: first-level products.
      d1_r   <= in_data;
      r00_r  <= mul30(in_sc[1].c, in_sc[2].c);
      r01_r  <= mul30(in_sc[1].c, in_sc[2].s);
      r02_r  <= -in_sc[1].s;
      r12_r  <= mul30(in_sc[0].s, in_sc[1].c);
      r22_r  <= mul30(in_sc[0].c, in_sc[1].c);
      cxsz_r <= mul30(in_sc[0].c, in_sc[2].s);
      cxcz_r <= mul30(in_sc[0].c, in_sc[2].c);
      sxsz_r <= mul30(in_sc[0].s, in_sc[2].s);
      sxcz_r <= mul30(in_sc[0].s, in_sc[2].c);
      sxsy_r <= mul30(in_sc[0].s, in_sc[1].s);
      cxsy_r <= mul30(in_sc[0].c, in_sc[1].s);
      cz_r2  <= in_sc[2].c;
      sz_r2  <= in_sc[2].s;
      // Stage B: second-level products and sums.
      d2_r   <= d1_r;
      r00b_r <= r00_r;
      r01b_r <= r01_r;
      r02b_r <= r02_r;
      r12b_r <= r12_r;
      r22b_r <= r22_r;
      r10_r  <= -cxsz_r + mul30(sxsy_r, cz_r2);
      r11_r  <= cxcz_r + mul30(sxsy_r, sz_r2);
      r20_r  <= sxsz_r + mul30(cxsy_r, cz_r2);
      r21_r  <= -sxcz_r + mul30(cxsy_r, sz_r2);
      // Stage C: scale and saturate.
      rows_r[0] <= '{2'd0, scaled(d2_r.scale_x, r00b_r), scaled(d2_r.scale_x, r01b_r),
                     scaled(d2_r.scale_x, r02b_r), 32'sd0, 1'b0};
      rows_r[1] <= '{2'd1, scaled(d2_r.scale_y, r10_r), scaled(d2_r.scale_y, r11_r),
                     scaled(d2_r.scale_y, r12b_r), 32'sd0, 1'b0};
      rows_r[2] <= '{2'd2, scaled(d2_r.scale_z, r20_r), scaled(d2_r.scale_z, r21_r),
                     scaled(d2_r.scale_z, r22b_r), 32'sd0, 1'b0};
      rows_r[3] <= '{2'd3, d2_r.trans_x, d2_r.trans_y, d2_r.trans_z, Q16One, 1'b1};
    end
  end

  assign out_vld  = vld_r[2];
  assign out_rows = rows_r;
endmodule
